[src/mrta_pkg.sv]
// shared types, codes and the control store for the range type entry allocator
// used by the top level, the free slot finder and the port checker
package mrta_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int IDX_W         = 3;
  localparam int TYPE_W        = 3;
  localparam int CNT_W         = 4;
  localparam int BIT_W         = 5;
  localparam int PC_W          = 3;

  localparam logic [31:0]       VALID_BIT  = 32'h0000_0800;
  localparam logic [31:0]       SIZE_MASK  = 32'hFFFF_F000;
  localparam logic [31:0]       ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [BIT_W-1:0]  TOP_BIT    = 5'd31;
  localparam logic [TYPE_W-1:0] MT_WC      = 3'd1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_MIS    = 2'd2;
  localparam logic [1:0] ST_SKIP   = 2'd3;

  // register indexes
  localparam logic [3:0] REG_FEATURE = 4'd0;
  localparam logic [3:0] REG_DEFTYPE = 4'd1;
  localparam logic [3:0] REG_WC      = 4'd2;
  localparam logic [3:0] REG_ENTRIES = 4'd3;

  // sequencer steps
  localparam logic [PC_W-1:0] S_WAIT  = 3'd0;
  localparam logic [PC_W-1:0] S_CHECK = 3'd1;
  localparam logic [PC_W-1:0] S_EMPTY = 3'd2;
  localparam logic [PC_W-1:0] S_SCAN  = 3'd3;
  localparam logic [PC_W-1:0] S_PLACE = 3'd4;
  localparam logic [PC_W-1:0] S_NEXT  = 3'd5;

  // branch conditions
  localparam logic [2:0] C_IN_VALID = 3'd0;
  localparam logic [2:0] C_SKIP     = 3'd1;
  localparam logic [2:0] C_EMPTY    = 3'd2;
  localparam logic [2:0] C_BIT_SET  = 3'd3;
  localparam logic [2:0] C_MISALIGN = 3'd4;
  localparam logic [2:0] C_DONE     = 3'd5;

  // datapath operations
  localparam logic [2:0] OP_NONE       = 3'd0;
  localparam logic [2:0] OP_DEC        = 3'd1;
  localparam logic [2:0] OP_EMIT_SKIP  = 3'd2;
  localparam logic [2:0] OP_EMIT_MIS   = 3'd3;
  localparam logic [2:0] OP_EMIT_BLOCK = 3'd4;

  typedef struct packed {
    logic [2:0]      cond;
    logic [2:0]      op_true;
    logic [2:0]      op_false;
    logic [PC_W-1:0] jmp_true;
    logic [PC_W-1:0] jmp_false;
  } ucode_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } slot_res_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      S_WAIT:  w = '{C_IN_VALID, OP_NONE,       OP_NONE,      S_CHECK, S_WAIT};
      S_CHECK: w = '{C_SKIP,     OP_EMIT_SKIP,  OP_NONE,      S_WAIT,  S_EMPTY};
      S_EMPTY: w = '{C_EMPTY,    OP_NONE,       OP_NONE,      S_WAIT,  S_SCAN};
      S_SCAN:  w = '{C_BIT_SET,  OP_NONE,       OP_DEC,       S_PLACE, S_SCAN};
      S_PLACE: w = '{C_MISALIGN, OP_EMIT_MIS,   OP_EMIT_BLOCK, S_WAIT, S_NEXT};
      S_NEXT:  w = '{C_DONE,     OP_NONE,       OP_DEC,       S_WAIT,  S_SCAN};
      default: w = '{C_IN_VALID, OP_NONE,       OP_NONE,      S_WAIT,  S_WAIT};
    endcase
    return w;
  endfunction

endpackage

[src/memory_range_type_entry_allocator.sv]
// top level of the range type entry allocator: control store sequencer and datapath
// depends on mrta_pkg and mrta_slot_find
//
// usage
//   in_*  : one request item (base address, size, memory type); taken only while
//           the sequencer sits in its wait step, so one request is worked at a time
//   out_* : result items, one per power-of-two block of the size, or one item when
//           the request is skipped; a misaligned block gives one item that ends the
//           request; tlast marks the final item, an empty size not skipped gives no item
//   cfg_* : register writes, always ready, index 0..3, other indexes ignored
// sequence
//   a skipped request ends at the check step with its skip item; any other passes the
//   check and empty steps, then the six-step program walks the size bits from bit 31
//   down, one bit per scan step, and each set bit goes to the S_PLACE step
//   the skip item is registered from the check step, any other item from S_PLACE
// reset
//   clears all entry valid bits and registers; entries_in_use comes up as 8
// stall
//   the result register holds while out_tready is low; the sequencer waits on
//   any step that emits until the register is free
module memory_range_type_entry_allocator
  import mrta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // base_address[31:0], range_size[63:32], mem_type[66:64], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // entry_index[2:0], base_word[34:3], mask_word[66:35], zero
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  // configuration
  logic              feature_r;
  logic [TYPE_W-1:0] deftype_r;
  logic              wc_r;
  logic [CNT_W-1:0]  entries_r;

  // sequencer and datapath
  logic [PC_W-1:0]          pc_r, pc_nxt;
  logic [31:0]              addr_r, addr_nxt;
  logic [31:0]              size_r, size_nxt;
  logic [TYPE_W-1:0]        type_r, type_nxt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [31:0]       out_base_r, out_base_nxt;
  logic [31:0]       out_mask_r, out_mask_nxt;
  logic [1:0]        out_stat_r, out_stat_nxt;
  logic              out_last_r, out_last_nxt;

  ucode_t     uw;
  logic       cond;
  logic [2:0] op;
  logic       emit;
  logic       out_free;
  logic       stall;
  logic [31:0] block;
  logic [31:0] size_clr;
  slot_res_t  slot;

  mrta_slot_find u_find (
    .valid          (valid_r),
    .entries_in_use (entries_r),
    .res            (slot)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (pc_r == S_WAIT);

  assign block    = 32'd1 << bit_r;
  assign size_clr = size_r & ~block;
  assign uw       = ucode_rom(pc_r);

  always_comb begin
    case (uw.cond)
      C_IN_VALID: cond = in_tvalid;
      C_SKIP:     cond = !feature_r || (type_r == deftype_r) || ((type_r == MT_WC) && !wc_r);
      C_EMPTY:    cond = (size_r == 32'd0);
      C_BIT_SET:  cond = size_r[bit_r];
      C_MISALIGN: cond = ((addr_r & (block - 32'd1)) != 32'd0);
      C_DONE:     cond = (size_r == 32'd0);
      default:    cond = 1'b0;
    endcase
  end

  assign op       = cond ? uw.op_true : uw.op_false;
  assign emit     = (op == OP_EMIT_SKIP) || (op == OP_EMIT_MIS) || (op == OP_EMIT_BLOCK);
  assign out_free = !out_valid_r || out_tready;
  assign stall    = emit && !out_free;

  always_comb begin
    pc_nxt        = pc_r;
    addr_nxt      = addr_r;
    size_nxt      = size_r;
    type_nxt      = type_r;
    bit_nxt       = bit_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_base_nxt  = out_base_r;
    out_mask_nxt  = out_mask_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;

    if (!stall) begin
      pc_nxt = cond ? uw.jmp_true : uw.jmp_false;
      if (in_tvalid && in_tready) begin
        addr_nxt = in_tdata[31:0];
        size_nxt = in_tdata[63:32] & SIZE_MASK;
        type_nxt = in_tdata[66:64];
        bit_nxt  = TOP_BIT;
      end
      case (op)
        OP_DEC: begin
          bit_nxt = bit_r - 5'd1;
        end
        OP_EMIT_SKIP, OP_EMIT_MIS: begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          out_base_nxt  = '0;
          out_mask_nxt  = '0;
          out_stat_nxt  = (op == OP_EMIT_SKIP) ? ST_SKIP : ST_MIS;
          out_last_nxt  = 1'b1;
        end
        OP_EMIT_BLOCK: begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = slot.found ? IDX_W'(slot.slot) : '0;
          out_base_nxt  = addr_r | {{(32-TYPE_W){1'b0}}, type_r};
          out_mask_nxt  = (ALL_ONES << bit_r) | VALID_BIT;
          out_stat_nxt  = slot.found ? ST_OK : ST_NOFREE;
          out_last_nxt  = (size_clr == 32'd0);
          if (slot.found) begin
            valid_nxt[slot.slot] = 1'b1;
          end
          // address moves on whether or not the block found an entry
          addr_nxt = addr_r + block;
          size_nxt = size_clr;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_WAIT;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      feature_r   <= 1'b0;
      deftype_r   <= '0;
      wc_r        <= 1'b0;
      entries_r   <= CNT_W'(TABLE_ENTRIES);
    end else begin
      pc_r        <= pc_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FEATURE: feature_r <= cfg_data[0];
          REG_DEFTYPE: deftype_r <= cfg_data[TYPE_W-1:0];
          REG_WC:      wc_r      <= cfg_data[0];
          REG_ENTRIES: entries_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    size_r     <= size_nxt;
    type_r     <= type_nxt;
    bit_r      <= bit_nxt;
    out_idx_r  <= out_idx_nxt;
    out_base_r <= out_base_nxt;
    out_mask_r <= out_mask_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_mask_r, out_base_r, out_idx_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule

[src/mrta_slot_find.sv]
// lowest free table entry among the entries in use
// depends on mrta_pkg
module mrta_slot_find
  import mrta_pkg::*;
(
  input  logic [TABLE_ENTRIES-1:0] valid,
  input  logic [CNT_W-1:0]         entries_in_use,
  output slot_res_t                res
);

  always_comb begin
    res = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i] && (i < int'(entries_in_use))) begin
        res.found = 1'b1;
        res.slot  = SLOT_W'(i);
      end
    end
  end

endmodule

[src/mrta_checker.sv]
// port-level checks for the range type entry allocator, bound to the top level
// depends on mrta_pkg
module mrta_checker
  import mrta_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled item stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  // only a written entry reports an index
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[2:0] == 3'd0))
    else $error("index on a result that wrote no entry");

  // a skip or misalignment ends the request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_SKIP) || (out_tuser == ST_MIS)) |-> out_tlast)
    else $error("skip or misaligned result without last");

  // a block result always carries the valid bit in its mask word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_OK) || (out_tuser == ST_NOFREE)) |-> out_tdata[46])
    else $error("block result mask word lacks valid bit");

endmodule

bind memory_range_type_entry_allocator mrta_checker u_mrta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[sim/tb_memory_range_type_entry_allocator.sv]
// testbench for memory_range_type_entry_allocator: directed and random requests checked
// against an in-bench table shadow, with random stalls on both streams
// depends on mrta_pkg and the allocator rtl
module tb_memory_range_type_entry_allocator;
  import mrta_pkg::*;

  localparam int IDLE_PCT      = 31;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_CAP     = 60;

  // register indexes the block ignores
  localparam logic [3:0] REG_UNUSED_LO = 4'd4;
  localparam logic [3:0] REG_UNUSED_HI = 4'd15;

  // memory type codes used by the directed tests
  localparam logic [TYPE_W-1:0] MT_UC   = 3'd0;
  localparam logic [TYPE_W-1:0] MT_RSV2 = 3'd2;
  localparam logic [TYPE_W-1:0] MT_RSV3 = 3'd3;
  localparam logic [TYPE_W-1:0] MT_WT   = 3'd4;
  localparam logic [TYPE_W-1:0] MT_WP   = 3'd5;
  localparam logic [TYPE_W-1:0] MT_WB   = 3'd6;
  localparam logic [TYPE_W-1:0] MT_RSV7 = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic [31:0]      base_word;
    logic [31:0]      mask_word;
    logic [1:0]       status;
    logic             last;
  } alloc_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index  = '0;
  logic [3:0]  cfg_data   = '0;

  // shadow of the block's registers and entry table
  logic              reg_feature = 1'b0;
  logic [TYPE_W-1:0] reg_deftype = '0;
  logic              reg_wc      = 1'b0;
  logic [CNT_W-1:0]  reg_entries = 4'd8;
  logic [31:0]       slot_base [TABLE_ENTRIES];
  logic [31:0]       slot_mask [TABLE_ENTRIES];

  alloc_result_t awaited_results [$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  bit            steady         = 1'b0;
  logic          rx_hold        = 1'b0;
  event          hold_off_go;

  memory_range_type_entry_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("memory_range_type_entry_allocator regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // predicts the result items: one skip item, or a walk of the size bits largest first that fills the shadow table
  task automatic predict_placement(input logic [31:0] addr_in, input logic [31:0] size,
                                   input logic [TYPE_W-1:0] mtype);
    logic [31:0]   addr;
    logic [31:0]   blk_size;
    logic [31:0]   blk_mask;
    int            limit;
    int            slot;
    bit            found;
    bit            stopped;
    bit            have_prev;
    alloc_result_t prev;
    alloc_result_t r;
    addr      = addr_in;
    limit     = (reg_entries > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(reg_entries);
    stopped   = 1'b0;
    have_prev = 1'b0;
    prev      = '0;
    if (!reg_feature || mtype == reg_deftype || (mtype == MT_WC && !reg_wc)) begin
      r = '0;
      r.status = ST_SKIP;
      r.last   = 1'b1;
      awaited_results.push_back(r);
    end else begin
      for (int b = 31; b >= 12 && !stopped; b--) begin
        blk_size = 32'h1 << b;
        blk_mask = ALL_ONES << b;
        if ((size & blk_size) != 0) begin
          r = '0;
          if ((addr & (blk_size - 1)) != 0) begin
            r.status = ST_MIS;
            stopped  = 1'b1;
          end else begin
            found = 1'b0;
            slot  = 0;
            for (int s = 0; s < limit; s++)
              if (!found && (slot_mask[s] & VALID_BIT) == 0) begin
                found = 1'b1;
                slot  = s;
              end
            r.base_word = addr | mtype;
            r.mask_word = blk_mask | VALID_BIT;
            if (found) begin
              slot_base[slot] = r.base_word;
              slot_mask[slot] = r.mask_word;
              r.entry_index   = slot[IDX_W-1:0];
              r.status        = ST_OK;
            end else begin
              r.status = ST_NOFREE;
            end
            addr = addr + blk_size;
          end
          if (have_prev) awaited_results.push_back(prev);
          prev      = r;
          have_prev = 1'b1;
        end
      end
      // an empty size gives no item at all
      if (have_prev) begin
        prev.last = 1'b1;
        awaited_results.push_back(prev);
      end
    end
  endtask

  task automatic check_result();
    alloc_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result item with none awaited, base_word", out_tdata[34:3], '0);
      return;
    end
    want = awaited_results.pop_front();
    if (out_tdata[2:0] !== want.entry_index)
      report_mismatch("entry_index", 32'(out_tdata[2:0]), 32'(want.entry_index));
    if (out_tdata[34:3] !== want.base_word)
      report_mismatch("base_word", out_tdata[34:3], want.base_word);
    if (out_tdata[66:35] !== want.mask_word)
      report_mismatch("mask_word", out_tdata[66:35], want.mask_word);
    if (out_tuser !== want.status)
      report_mismatch("status", 32'(out_tuser), 32'(want.status));
    if (out_tlast !== want.last)
      report_mismatch("last", 32'(out_tlast), 32'(want.last));
  endtask

  // result side: random stalls, plus the long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      out_tready <= !rx_hold && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    forever begin
      @(hold_off_go);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  task automatic send_request(input logic [31:0] addr, input logic [31:0] size,
                              input logic [TYPE_W-1:0] mtype);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, mtype, size, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_placement(addr, size, mtype);
  endtask

  task automatic send_random_request();
    logic [31:0]       addr;
    logic [31:0]       size;
    logic [31:0]       span;
    logic [TYPE_W-1:0] mtype;
    int                top;
    int                pick;
    pick  = $urandom_range(99);
    top   = ($urandom_range(3) == 0) ? $urandom_range(31, 12) : $urandom_range(20, 12);
    span  = ALL_ONES >> (31 - top);
    // well formed: base aligned to the largest block of the size
    size  = ($urandom() & span) | (32'h1 << top);
    addr  = $urandom() & ~(span >> 1);
    mtype = TYPE_W'($urandom_range(7));
    if (pick < 12) begin
      addr = $urandom();
      size = $urandom();
    end else if (pick < 22) begin
      size = $urandom() & ~SIZE_MASK;
    end else if (pick < 35) begin
      addr = addr | (32'h1 << $urandom_range(top - 1, 0));
    end
    send_request(addr, size, mtype);
  endtask

  task automatic write_register(input logic [3:0] idx, input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FEATURE: reg_feature = value[0];
      REG_DEFTYPE: reg_deftype = value[TYPE_W-1:0];
      REG_WC:      reg_wc      = value[0];
      REG_ENTRIES: reg_entries = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // an empty request gives no item to wait for, so let the sequencer settle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] feature, input logic [3:0] deftype,
                           input logic [3:0] wc, input logic [3:0] entries);
    wait_idle();
    write_register(REG_FEATURE, feature);
    write_register(REG_DEFTYPE, deftype);
    write_register(REG_WC, wc);
    write_register(REG_ENTRIES, entries);
  endtask

  // registers at reset: table absent, so everything is skipped, even an empty size
  task automatic test_reset_defaults();
    send_request(32'h0000_1000, 32'h0000_1000, MT_RSV3);
    send_request(32'h0000_0000, 32'h0000_0000, MT_UC);
  endtask

  task automatic test_skip_rules();
    wait_idle();
    write_register(REG_UNUSED_LO, 4'hF);
    write_register(REG_UNUSED_HI, 4'h5);
    configure(4'hF, {1'b1, MT_RSV2}, 4'hE, 4'd2);
    send_request(32'h0000_4000, 32'h0000_1000, MT_RSV2);
    send_request(32'h0000_4000, 32'h0000_1000, MT_WC);
  endtask

  task automatic test_empty_and_misaligned();
    send_request(32'h1234_5000, 32'h0000_0FFF, MT_WP);
    send_request(32'h0000_1000, 32'h0000_2000, MT_WT);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, MT_RSV7);
    send_request(32'h0000_0800, 32'h0000_1000, MT_WB);
  endtask

  // 2 gb block then 1 gb block past the top of the address space, then a full walk
  task automatic test_placement_and_wrap();
    send_request(32'h8000_0000, 32'hC000_0000, MT_WB);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, MT_RSV3);
    send_request(32'h0000_0000, 32'h0000_1000, MT_UC);
  endtask

  task automatic test_zero_entries();
    configure(4'd1, {1'b0, MT_RSV7}, 4'd1, 4'd0);
    send_request(32'h0000_3000, 32'h0000_1000, MT_WC);
    send_request(32'h0000_0000, 32'h8000_0FFF, MT_UC);
    send_request(32'h0000_0000, 32'h0000_0000, MT_WB);
  endtask

  task automatic test_random_traffic(input int count, input logic [3:0] feature,
                                     input logic [3:0] deftype, input logic [3:0] wc,
                                     input logic [3:0] entries);
    configure(feature, deftype, wc, entries);
    repeat (count) send_random_request();
  endtask

  // results pile up while the receiver holds off, then a run with no idling
  task automatic test_output_backpressure();
    configure(4'd1, {1'b0, MT_WP}, 4'd0, 4'd6);
    -> hold_off_go;
    repeat (16) send_random_request();
    steady = 1'b1;
    repeat (45) send_random_request();
    wait_idle();
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_base[i] = '0;
      slot_mask[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_skip_rules();
    test_empty_and_misaligned();
    test_placement_and_wrap();
    test_zero_entries();
    test_random_traffic(60, 4'd1, {1'b0, MT_UC}, 4'd1, 4'd4);
    test_random_traffic(20, 4'd0, {1'b0, MT_RSV7}, 4'd0, 4'd8);
    test_output_backpressure();
    test_random_traffic(100, 4'd3, {1'b0, MT_RSV3}, 4'd1, 4'd15);
    test_random_traffic(80, 4'd1, {1'b0, MT_UC}, 4'd0, 4'd8);
    wait_idle();
    if (mismatch_count == 0)
      $display("memory_range_type_entry_allocator regression: pass");
    else
      $display("memory_range_type_entry_allocator regression: fail");
    $finish;
  end

endmodule

[sim.f]
src/mrta_pkg.sv
src/mrta_slot_find.sv
src/memory_range_type_entry_allocator.sv
src/mrta_checker.sv
sim/tb_memory_range_type_entry_allocator.sv
